### rtl/vbsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbsc_pkg
// Shared constants, codes and control types of the volume box-sum counter.
// ----------------------------------------------------------------------------
package vbsc_pkg;

    localparam int MAX_X_DEF = 16;
    localparam int MAX_Y_DEF = 16;
    localparam int MAX_Z_DEF = 16;

    localparam int QW      = 4;
    localparam int DW      = 17;
    localparam int CNT_W   = 48;
    localparam int ST_W    = 2;
    localparam int GS_W    = 5;
    localparam int RAD_W   = 4;
    localparam int MEAS_W  = 32;
    localparam int ACC_W   = 32;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 32;
    localparam int STEP_W  = 3;

    localparam logic [CFG_IW-1:0] CFG_GRID_X  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GRID_Y  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_GRID_Z  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_RADIUS  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_THIN    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_MEASURE = 3'd5;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE      = 2'd2;

    localparam logic [GS_W-1:0]   GRID_RST    = 5'd16;
    localparam logic [RAD_W-1:0]  RADIUS_RST  = 4'd1;
    localparam logic [MEAS_W-1:0] MEASURE_RST = 32'd65536;

    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ONE   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd7;

    typedef struct packed {
        logic              accept;
        logic              rd_en;
        logic [STEP_W-1:0] step;
        logic              wr_en;
        logic              mul_en;
        logic              mul_k;
        logic              out_load;
    } vbsc_cmd_t;

    typedef struct packed {
        logic go_load;
        logic go_query;
    } vbsc_stat_t;

endpackage
`default_nettype wire

### rtl/vbsc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbsc_req_if
// Request channel: load voxel or query box sums.
// ----------------------------------------------------------------------------
interface vbsc_req_if;
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [vbsc_pkg::QW-1:0] query_x;
    logic [vbsc_pkg::QW-1:0] query_y;
    logic [vbsc_pkg::QW-1:0] query_z;
    logic [vbsc_pkg::DW-1:0] r_small_density;
    logic [vbsc_pkg::DW-1:0] r_large_density;
    logic [vbsc_pkg::DW-1:0] k_small_density;
    logic [vbsc_pkg::DW-1:0] k_large_density;

    modport source (
        output valid, action, query_x, query_y, query_z,
        output r_small_density, r_large_density, k_small_density, k_large_density,
        input  ready
    );
    modport sink (
        input  valid, action, query_x, query_y, query_z,
        input  r_small_density, r_large_density, k_small_density, k_large_density,
        output ready
    );
endinterface
`default_nettype wire

### rtl/vbsc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbsc_rsp_if
// Response channel: scaled box sums, status and load state.
// ----------------------------------------------------------------------------
interface vbsc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [vbsc_pkg::CNT_W-1:0] r_count;
    logic [vbsc_pkg::CNT_W-1:0] k_count;
    logic [vbsc_pkg::ST_W-1:0]  status;
    logic                       table_loaded;

    modport source (output valid, r_count, k_count, status, table_loaded, input ready);
    modport sink   (input valid, r_count, k_count, status, table_loaded, output ready);
endinterface
`default_nettype wire

### rtl/vbsc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbsc_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module vbsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4913
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/vbsc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbsc_ctrl
// Sequencer: table reads, write-back or scaling, and response hand-off.
// ----------------------------------------------------------------------------
module vbsc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    input  wire vbsc_pkg::vbsc_stat_t stat,
    output vbsc_pkg::vbsc_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_LAST,
        S_WR,
        S_MULR,
        S_MULK,
        S_FIN
    } state_t;

    state_t                      state_reg;
    logic [vbsc_pkg::STEP_W-1:0] step_reg;
    logic                        load_reg;
    logic                        out_valid_reg;
    logic                        take;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign take      = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = in_ready && in_valid;
        cmd.rd_en    = (state_reg == S_RD);
        cmd.step     = (state_reg == S_RD) ? step_reg : vbsc_pkg::STEP_FIRST;
        cmd.wr_en    = (state_reg == S_WR);
        cmd.mul_en   = (state_reg == S_MULR) || (state_reg == S_MULK);
        cmd.mul_k    = (state_reg == S_MULK);
        cmd.out_load = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= vbsc_pkg::STEP_FIRST;
            load_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        load_reg <= stat.go_load;
                        if (stat.go_load)
                        begin
                            step_reg  <= vbsc_pkg::STEP_ONE;
                            state_reg <= S_RD;
                        end
                        else if (stat.go_query)
                        begin
                            step_reg  <= vbsc_pkg::STEP_FIRST;
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_RD:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == vbsc_pkg::STEP_LAST)
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:  state_reg <= load_reg ? S_WR : S_MULR;
                S_WR:    state_reg <= S_FIN;
                S_MULR:  state_reg <= S_MULK;
                S_MULK:  state_reg <= S_FIN;
                S_FIN:
                begin
                    if (take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/vbsc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbsc_dp
// Datapath: config registers, load position, corner addressing, accumulators,
// measure scaling and response registers.
// ----------------------------------------------------------------------------
module vbsc_dp #(
    parameter int MAX_X = vbsc_pkg::MAX_X_DEF,
    parameter int MAX_Y = vbsc_pkg::MAX_Y_DEF,
    parameter int MAX_Z = vbsc_pkg::MAX_Z_DEF,
    localparam int DEPTH = (MAX_X + 1) * (MAX_Y + 1) * (MAX_Z + 1),
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [vbsc_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [vbsc_pkg::CFG_DW-1:0]   cfg_data,
    input  wire logic                          action,
    input  wire logic [vbsc_pkg::QW-1:0]       query_x,
    input  wire logic [vbsc_pkg::QW-1:0]       query_y,
    input  wire logic [vbsc_pkg::QW-1:0]       query_z,
    input  wire logic [vbsc_pkg::DW-1:0]       r_small_density,
    input  wire logic [vbsc_pkg::DW-1:0]       r_large_density,
    input  wire logic [vbsc_pkg::DW-1:0]       k_small_density,
    input  wire logic [vbsc_pkg::DW-1:0]       k_large_density,
    input  wire vbsc_pkg::vbsc_cmd_t           cmd,
    output vbsc_pkg::vbsc_stat_t               stat,
    output logic                               ram_en,
    output logic                               ram_we,
    output logic [AW-1:0]                      ram_addr,
    output logic [2*vbsc_pkg::ACC_W-1:0]       ram_wdata,
    input  wire logic [2*vbsc_pkg::ACC_W-1:0]  ram_rdata,
    output logic [vbsc_pkg::CNT_W-1:0]         r_count,
    output logic [vbsc_pkg::CNT_W-1:0]         k_count,
    output logic [vbsc_pkg::ST_W-1:0]          status,
    output logic                               table_loaded
);

    localparam int MAXC = (MAX_X > MAX_Y) ? ((MAX_X > MAX_Z) ? MAX_X : MAX_Z)
                                          : ((MAX_Y > MAX_Z) ? MAX_Y : MAX_Z);
    localparam int CW   = $clog2(MAXC + 1);
    localparam int EW   = (CW > vbsc_pkg::GS_W) ? CW : vbsc_pkg::GS_W;
    localparam int VW   = vbsc_pkg::DW + 1;
    localparam int AccW = vbsc_pkg::ACC_W;
    localparam int PW   = AccW + vbsc_pkg::MEAS_W;

    function automatic logic [CW-1:0] clamp_size(input logic [vbsc_pkg::GS_W-1:0] v,
                                                 input int maxv);
        if (v == '0)
        begin
            return CW'(1);
        end
        if (int'(v) > maxv)
        begin
            return CW'(maxv);
        end
        return CW'(v);
    endfunction

    function automatic logic [CW-1:0] lo_bound(input logic [vbsc_pkg::QW-1:0] q,
                                               input logic [vbsc_pkg::RAD_W-1:0] r);
        return (q > r) ? CW'(q - r) : '0;
    endfunction

    function automatic logic [CW-1:0] hi_bound(input logic [vbsc_pkg::QW-1:0] q,
                                               input logic [vbsc_pkg::RAD_W-1:0] r,
                                               input logic [CW-1:0] n);
        logic [EW-1:0] h;
        h = EW'(q) + EW'(r) + EW'(1);
        return (h < EW'(n)) ? CW'(h) : n;
    endfunction

    logic [vbsc_pkg::GS_W-1:0]   gsx_reg, gsy_reg, gsz_reg;
    logic [vbsc_pkg::RAD_W-1:0]  rad_reg;
    logic                        thin_reg;
    logic [vbsc_pkg::MEAS_W-1:0] meas_reg;

    logic [CW-1:0] lx_reg, ly_reg, lz_reg;
    logic          full_reg;

    logic          load_reg;
    logic          qok_reg;
    logic [vbsc_pkg::ST_W-1:0] st_reg;
    logic [CW-1:0] x0_reg, y0_reg, z0_reg, x1_reg, y1_reg, z1_reg;

    logic          rdv_reg, add_reg, bord_reg;
    logic [AccW-1:0] accr_reg, acck_reg;
    logic [vbsc_pkg::CNT_W-1:0] prodr_reg, prodk_reg;

    logic [vbsc_pkg::CNT_W-1:0] rout_reg, kout_reg;
    logic [vbsc_pkg::ST_W-1:0]  stout_reg;
    logic                       tlout_reg;

    logic [CW-1:0] nx, ny, nz;
    logic          in_grid;
    logic [vbsc_pkg::ST_W-1:0] st_next;
    logic [VW-1:0] vr, vk;
    logic [CW-1:0] ax, ay, az;
    logic          step_add, step_bord;
    logic [AccW-1:0] rd_r, rd_k;
    logic [AccW-1:0] mul_op;
    logic [PW-1:0]   prod;
    logic          restart;

    assign nx = clamp_size(gsx_reg, MAX_X);
    assign ny = clamp_size(gsy_reg, MAX_Y);
    assign nz = clamp_size(gsz_reg, MAX_Z);

    assign in_grid = (EW'(query_x) < EW'(nx)) && (EW'(query_y) < EW'(ny))
                  && (EW'(query_z) < EW'(nz));

    assign stat.go_load  = !action && !full_reg;
    assign stat.go_query = action && full_reg && in_grid;

    always_comb
    begin
        if (!action)
        begin
            st_next = full_reg ? vbsc_pkg::ST_RANGE : vbsc_pkg::ST_OK;
        end
        else if (!full_reg)
        begin
            st_next = vbsc_pkg::ST_NOT_LOADED;
        end
        else
        begin
            st_next = in_grid ? vbsc_pkg::ST_OK : vbsc_pkg::ST_RANGE;
        end
    end

    assign vr = VW'(r_small_density) + VW'(r_large_density);
    assign vk = VW'(k_small_density) + VW'(k_large_density);

    // corner of the current step: loads walk back from the new voxel,
    // queries pick lower or upper bound per axis
    always_comb
    begin
        if (load_reg)
        begin
            ax = (lx_reg + CW'(1)) - CW'(cmd.step[0]);
            ay = (ly_reg + CW'(1)) - CW'(cmd.step[1]);
            az = (lz_reg + CW'(1)) - CW'(cmd.step[2]);
            step_add = ^cmd.step;
        end
        else
        begin
            ax = cmd.step[0] ? x0_reg : x1_reg;
            ay = cmd.step[1] ? y0_reg : y1_reg;
            az = cmd.step[2] ? z0_reg : z1_reg;
            step_add = ~(^cmd.step);
        end
    end

    assign step_bord = (ax == '0) || (ay == '0) || (az == '0);

    assign ram_addr  = AW'((int'(az) * (MAX_Y + 1) + int'(ay)) * (MAX_X + 1) + int'(ax));
    assign ram_we    = cmd.wr_en;
    assign ram_en    = cmd.wr_en || (cmd.rd_en && !step_bord);
    assign ram_wdata = {accr_reg, acck_reg};

    assign rd_r = ram_rdata[2*AccW-1:AccW];
    assign rd_k = ram_rdata[AccW-1:0];

    assign mul_op = cmd.mul_k ? acck_reg : accr_reg;
    assign prod   = PW'(mul_op) * PW'(meas_reg);

    assign restart = cfg_we && ((cfg_index == vbsc_pkg::CFG_GRID_X)
                             || (cfg_index == vbsc_pkg::CFG_GRID_Y)
                             || (cfg_index == vbsc_pkg::CFG_GRID_Z));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsx_reg  <= vbsc_pkg::GRID_RST;
            gsy_reg  <= vbsc_pkg::GRID_RST;
            gsz_reg  <= vbsc_pkg::GRID_RST;
            rad_reg  <= vbsc_pkg::RADIUS_RST;
            thin_reg <= 1'b0;
            meas_reg <= vbsc_pkg::MEASURE_RST;
            lx_reg   <= '0;
            ly_reg   <= '0;
            lz_reg   <= '0;
            full_reg <= 1'b0;
            load_reg <= 1'b0;
            rdv_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    vbsc_pkg::CFG_GRID_X:  gsx_reg  <= cfg_data[vbsc_pkg::GS_W-1:0];
                    vbsc_pkg::CFG_GRID_Y:  gsy_reg  <= cfg_data[vbsc_pkg::GS_W-1:0];
                    vbsc_pkg::CFG_GRID_Z:  gsz_reg  <= cfg_data[vbsc_pkg::GS_W-1:0];
                    vbsc_pkg::CFG_RADIUS:  rad_reg  <= cfg_data[vbsc_pkg::RAD_W-1:0];
                    vbsc_pkg::CFG_THIN:    thin_reg <= cfg_data[0];
                    vbsc_pkg::CFG_MEASURE: meas_reg <= cfg_data[vbsc_pkg::MEAS_W-1:0];
                    default: ;
                endcase
            end

            if (restart)
            begin
                lx_reg   <= '0;
                ly_reg   <= '0;
                lz_reg   <= '0;
                full_reg <= 1'b0;
            end
            else if (cmd.wr_en)
            begin
                if (lx_reg + CW'(1) >= nx)
                begin
                    lx_reg <= '0;
                    if (ly_reg + CW'(1) >= ny)
                    begin
                        ly_reg <= '0;
                        if (lz_reg + CW'(1) >= nz)
                        begin
                            lz_reg   <= '0;
                            full_reg <= 1'b1;
                        end
                        else
                        begin
                            lz_reg <= lz_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        ly_reg <= ly_reg + CW'(1);
                    end
                end
                else
                begin
                    lx_reg <= lx_reg + CW'(1);
                end
            end

            if (cmd.accept)
            begin
                load_reg <= !action;
            end
            rdv_reg <= cmd.rd_en;
        end
    end

    // item capture, accumulation, scaling, response
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            qok_reg <= stat.go_query;
            st_reg  <= st_next;
            x0_reg  <= lo_bound(query_x, rad_reg);
            y0_reg  <= lo_bound(query_y, rad_reg);
            x1_reg  <= hi_bound(query_x, rad_reg, nx);
            y1_reg  <= hi_bound(query_y, rad_reg, ny);
            if (thin_reg)
            begin
                z0_reg <= '0;
                z1_reg <= CW'(1);
            end
            else
            begin
                z0_reg <= lo_bound(query_z, rad_reg);
                z1_reg <= hi_bound(query_z, rad_reg, nz);
            end
            accr_reg <= action ? '0 : AccW'(vr);
            acck_reg <= action ? '0 : AccW'(vk);
        end
        else if (rdv_reg && !bord_reg)
        begin
            accr_reg <= add_reg ? accr_reg + rd_r : accr_reg - rd_r;
            acck_reg <= add_reg ? acck_reg + rd_k : acck_reg - rd_k;
        end

        add_reg  <= step_add;
        bord_reg <= step_bord;

        if (cmd.mul_en)
        begin
            if (cmd.mul_k)
            begin
                prodk_reg <= prod[PW-1:16];
            end
            else
            begin
                prodr_reg <= prod[PW-1:16];
            end
        end

        if (cmd.out_load)
        begin
            rout_reg  <= qok_reg ? prodr_reg : '0;
            kout_reg  <= qok_reg ? prodk_reg : '0;
            stout_reg <= st_reg;
            tlout_reg <= full_reg;
        end
    end

    assign r_count      = rout_reg;
    assign k_count      = kout_reg;
    assign status       = stout_reg;
    assign table_loaded = tlout_reg;

endmodule
`default_nettype wire

### rtl/volume_box_sum_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// volume_box_sum_counter
// Summed-volume tables of a 3D grid with clipped cube box-sum queries.
// ----------------------------------------------------------------------------
// Loads (action 0) enter voxels in raster order, x fastest; each builds one
// entry of the r and K summed-volume tables, which share one single-port RAM
// with registered read. A query (action 1) returns the r and K sums over the
// clipped cube scaled by voxel_measure. The table RAM port sets the rate.
// From the request transfer to the response, a load makes 7 neighbor reads
// and 1 write, a query makes 8 corner reads and two products on a shared
// multiplier, and an item answered by status alone goes straight to the
// output register. The next request is taken the cycle after the previous
// result enters the output register, so only one item is in flight; a
// stalled receiver holds off the next request. The zero border is produced
// by address decode and never stored, so there is no clearing pass after
// reset.
module volume_box_sum_counter #(
    parameter int MAX_X = vbsc_pkg::MAX_X_DEF,
    parameter int MAX_Y = vbsc_pkg::MAX_Y_DEF,
    parameter int MAX_Z = vbsc_pkg::MAX_Z_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [vbsc_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [vbsc_pkg::CFG_DW-1:0] cfg_data,
    vbsc_req_if.sink                         req,
    vbsc_rsp_if.source                       rsp
);

    localparam int DEPTH = (MAX_X + 1) * (MAX_Y + 1) * (MAX_Z + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = 2 * vbsc_pkg::ACC_W;

    vbsc_pkg::vbsc_cmd_t  cmd;
    vbsc_pkg::vbsc_stat_t stat;
    logic                 ram_en, ram_we;
    logic [AW-1:0]        ram_addr;
    logic [RW-1:0]        ram_wdata, ram_rdata;

    vbsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    vbsc_dp #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .action          (req.action),
        .query_x         (req.query_x),
        .query_y         (req.query_y),
        .query_z         (req.query_z),
        .r_small_density (req.r_small_density),
        .r_large_density (req.r_large_density),
        .k_small_density (req.k_small_density),
        .k_large_density (req.k_large_density),
        .cmd             (cmd),
        .stat            (stat),
        .ram_en          (ram_en),
        .ram_we          (ram_we),
        .ram_addr        (ram_addr),
        .ram_wdata       (ram_wdata),
        .ram_rdata       (ram_rdata),
        .r_count         (rsp.r_count),
        .k_count         (rsp.k_count),
        .status          (rsp.status),
        .table_loaded    (rsp.table_loaded)
    );

    vbsc_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // one item in flight: no transfer right after an accepted one
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while item in flight");

    // failed items carry no counts
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != vbsc_pkg::ST_OK))
            |-> ((rsp.r_count == '0) && (rsp.k_count == '0)))
        else $error("nonzero count with error status");

    // table write-back never overlaps a table read
    a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !cmd.rd_en)
        else $error("table read and write in same cycle");

endmodule
`default_nettype wire

### sim/volume_box_sum_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// volume_box_sum_checker
// Watches the config port and both channels of the volume box-sum counter,
// keeps its own summed-volume tables, and checks every response transfer
// field by field against the oldest predicted answer.
// ----------------------------------------------------------------------------
module volume_box_sum_checker
    import vbsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    vbsc_req_if               req,
    vbsc_rsp_if               rsp,
    output int                errors,
    output int                pending
);

    localparam int STRIDE = MAX_X_DEF + 1;
    localparam int DEPTH  = (MAX_X_DEF + 1) * (MAX_Y_DEF + 1) * (MAX_Z_DEF + 1);

    typedef struct packed {
        logic [CNT_W-1:0] r_count;
        logic [CNT_W-1:0] k_count;
        logic [ST_W-1:0]  status;
        logic             table_loaded;
    } box_answer_t;

    box_answer_t answers_due[$];

    logic [31:0]       sums [0:1][0:DEPTH-1];
    logic [GS_W-1:0]   size_x, size_y, size_z;
    logic [RAD_W-1:0]  radius;
    logic              thin;
    logic [MEAS_W-1:0] measure;
    logic [3:0]        lx, ly, lz;
    logic              full;

    box_answer_t want, got;
    int          nx, ny, nz, x0, y0, z0, x1, y1, z1, qx, qy, qz;
    logic [31:0] val [0:1];
    logic [31:0] s;
    logic [63:0] prod;

    function automatic int axis_size(logic [GS_W-1:0] v, int m);
        if (v == 0)
            return 1;
        return (int'(v) > m) ? m : int'(v);
    endfunction

    function automatic int at(int x, int y, int z);
        return (z * (MAX_Y_DEF + 1) + y) * STRIDE + x;
    endfunction

    function automatic logic [CNT_W-1:0] scaled(logic [31:0] sum, logic [31:0] m);
        logic [63:0] p;
        p = {32'd0, sum} * {32'd0, m};
        return p[16 +: CNT_W];
    endfunction

    task automatic report(string what, logic [63:0] g, logic [63:0] e);
        if (errors < 40)
            $display("mismatch %s: got %0h want %0h at %0t", what, g, e, $time);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x  <= GRID_RST;
            size_y  <= GRID_RST;
            size_z  <= GRID_RST;
            radius  <= RADIUS_RST;
            thin    <= 1'b0;
            measure <= MEASURE_RST;
            lx = 0; ly = 0; lz = 0;
            full = 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                sums[0][i] = '0;
                sums[1][i] = '0;
            end
            answers_due.delete();
            errors  = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_X:  size_x  <= cfg_data[GS_W-1:0];
                    CFG_GRID_Y:  size_y  <= cfg_data[GS_W-1:0];
                    CFG_GRID_Z:  size_z  <= cfg_data[GS_W-1:0];
                    CFG_RADIUS:  radius  <= cfg_data[RAD_W-1:0];
                    CFG_THIN:    thin    <= cfg_data[0];
                    CFG_MEASURE: measure <= cfg_data[MEAS_W-1:0];
                    default: ;
                endcase
                if (cfg_index == CFG_GRID_X || cfg_index == CFG_GRID_Y
                        || cfg_index == CFG_GRID_Z)
                begin
                    lx = 0; ly = 0; lz = 0;
                    full = 1'b0;
                end
            end
            if (req.valid && req.ready)
            begin
                nx = axis_size(size_x, MAX_X_DEF);
                ny = axis_size(size_y, MAX_Y_DEF);
                nz = axis_size(size_z, MAX_Z_DEF);
                want = '0;
                want.status = ST_OK;
                if (!req.action)
                begin
                    if (full)
                        want.status = ST_RANGE;
                    else
                    begin
                        val[0] = 32'(req.r_small_density) + 32'(req.r_large_density);
                        val[1] = 32'(req.k_small_density) + 32'(req.k_large_density);
                        x1 = lx + 1; y1 = ly + 1; z1 = lz + 1;
                        for (int t = 0; t < 2; t++)
                            sums[t][at(x1, y1, z1)] = val[t]
                                + sums[t][at(x1-1, y1, z1)] + sums[t][at(x1, y1-1, z1)]
                                + sums[t][at(x1, y1, z1-1)] - sums[t][at(x1-1, y1-1, z1)]
                                - sums[t][at(x1-1, y1, z1-1)] - sums[t][at(x1, y1-1, z1-1)]
                                + sums[t][at(x1-1, y1-1, z1-1)];
                        if (int'(lx) + 1 >= nx)
                        begin
                            lx = 0;
                            if (int'(ly) + 1 >= ny)
                            begin
                                ly = 0;
                                if (int'(lz) + 1 >= nz)
                                begin
                                    lz = 0;
                                    full = 1'b1;
                                end
                                else
                                    lz++;
                            end
                            else
                                ly++;
                        end
                        else
                            lx++;
                    end
                end
                else
                begin
                    qx = req.query_x; qy = req.query_y; qz = req.query_z;
                    if (!full)
                        want.status = ST_NOT_LOADED;
                    else if (qx >= nx || qy >= ny || qz >= nz)
                        want.status = ST_RANGE;
                    else
                    begin
                        x0 = (qx > radius) ? qx - radius : 0;
                        y0 = (qy > radius) ? qy - radius : 0;
                        z0 = (qz > radius) ? qz - radius : 0;
                        x1 = (qx + radius + 1 < nx) ? qx + radius + 1 : nx;
                        y1 = (qy + radius + 1 < ny) ? qy + radius + 1 : ny;
                        z1 = (qz + radius + 1 < nz) ? qz + radius + 1 : nz;
                        if (thin)
                        begin
                            z0 = 0;
                            z1 = 1;
                        end
                        for (int t = 0; t < 2; t++)
                        begin
                            s = sums[t][at(x1, y1, z1)]
                                - sums[t][at(x0, y1, z1)] - sums[t][at(x1, y0, z1)]
                                - sums[t][at(x1, y1, z0)] + sums[t][at(x0, y0, z1)]
                                + sums[t][at(x0, y1, z0)] + sums[t][at(x1, y0, z0)]
                                - sums[t][at(x0, y0, z0)];
                            if (t == 0)
                                want.r_count = scaled(s, measure);
                            else
                                want.k_count = scaled(s, measure);
                        end
                    end
                end
                want.table_loaded = full;
                answers_due.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.r_count, rsp.k_count, rsp.status, rsp.table_loaded};
                if (answers_due.size() == 0)
                    report("unexpected transfer", 0, 0);
                else
                begin
                    want = answers_due.pop_front();
                    if (got.r_count !== want.r_count)
                        report("r_count", got.r_count, want.r_count);
                    if (got.k_count !== want.k_count)
                        report("k_count", got.k_count, want.k_count);
                    if (got.status !== want.status)
                        report("status", got.status, want.status);
                    if (got.table_loaded !== want.table_loaded)
                        report("table_loaded", got.table_loaded, want.table_loaded);
                end
            end
            pending <= answers_due.size();
        end
    end

endmodule

### sim/volume_box_sum_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// volume_box_sum_counter_tb
// Drives grid loads and box-sum queries over many grid, radius, thin-layer
// and measure settings, with random idling on both channels and one long
// response hold-off; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module volume_box_sum_counter_tb;
    import vbsc_pkg::*;

    localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd7;
    localparam int                ITEM_GOAL  = 1550;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    int                errors;
    int                pending;
    int                idle_pct;
    int                stall_pct;
    bit                hold_rsp;
    int                items;

    vbsc_req_if req_ch ();
    vbsc_rsp_if rsp_ch ();

    volume_box_sum_counter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    volume_box_sum_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic int clamp_axis(int v);
        return (v == 0) ? 1 : (v > 16 ? 16 : v);
    endfunction

    function automatic logic [DW-1:0] density();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'd65535;
            default: return DW'($urandom_range(65536));
        endcase
    endfunction

    task automatic send(logic act, logic [3:0] qx, logic [3:0] qy, logic [3:0] qz);
        if ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.action          <= act;
        req_ch.query_x         <= qx;
        req_ch.query_y         <= qy;
        req_ch.query_z         <= qz;
        req_ch.r_small_density <= density();
        req_ch.r_large_density <= density();
        req_ch.k_small_density <= density();
        req_ch.k_large_density <= density();
        do
            @(posedge clk);
        while (!req_ch.ready);
        items++;
    endtask

    task automatic load_voxel();
        send(1'b0, 4'($urandom), 4'($urandom), 4'($urandom));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(int gx, int gy, int gz);
        set_reg(CFG_GRID_X, gx);
        set_reg(CFG_GRID_Y, gy);
        set_reg(CFG_GRID_Z, gz);
    endtask

    task automatic set_window(int rad, bit thn, logic [31:0] meas);
        set_reg(CFG_RADIUS, rad);
        set_reg(CFG_THIN, thn);
        set_reg(CFG_MEASURE, meas);
    endtask

    task automatic query_some(int n, int nx, int ny, int nz);
        for (int i = 0; i < n; i++)
            if ($urandom_range(9) == 0)
                send(1'b1, 4'($urandom), 4'($urandom), 4'($urandom));
            else
                send(1'b1, $urandom_range(nx-1), $urandom_range(ny-1), $urandom_range(nz-1));
    endtask

    task automatic random_phase(int ph);
        int gx, gy, gz, nx, ny, nz;
        logic [31:0] meas;
        case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 20; stall_pct = 20; end
        endcase
        case ($urandom_range(9))
            0: begin gx = 16; gy = $urandom_range(1, 2); gz = 1; end
            1: begin gx = 1; gy = 16; gz = $urandom_range(1, 2); end
            2: begin gx = $urandom_range(1, 2); gy = 1; gz = 16; end
            3: begin gx = $urandom_range(17, 31); gy = 0; gz = $urandom_range(0, 2); end
            default:
            begin
                gx = $urandom_range(1, 4);
                gy = $urandom_range(1, 4);
                gz = $urandom_range(1, 4);
            end
        endcase
        nx = clamp_axis(gx);
        ny = clamp_axis(gy);
        nz = clamp_axis(gz);
        case ($urandom_range(4))
            0: meas = 32'd0;
            1: meas = 32'hFFFF_FFFF;
            2: meas = MEASURE_RST;
            default: meas = $urandom;
        endcase
        wait_idle();
        set_grid(gx, gy, gz);
        set_window($urandom_range(2) == 0 ? $urandom_range(15) : $urandom_range(2),
                   $urandom_range(3) == 0, meas);
        if ($urandom_range(3) == 0)
            set_reg(CFG_UNUSED, $urandom);
        query_some($urandom_range(2), nx, ny, nz);
        for (int i = 0; i < nx * ny * nz; i++)
            load_voxel();
        for (int i = $urandom_range(2); i > 0; i--)
            load_voxel();
        query_some($urandom_range(10, 30), nx, ny, nz);
        if (ph == 5)
        begin
            idle_pct = 0;
            hold_rsp = 1'b1;
            query_some(20, nx, ny, nz);
        end
        wait_idle();
        set_window($urandom_range(15), $urandom_range(1), $urandom);
        query_some($urandom_range(5, 12), nx, ny, nz);
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        req_ch.valid           = 1'b0;
        req_ch.action          = 1'b0;
        req_ch.query_x         = '0;
        req_ch.query_y         = '0;
        req_ch.query_z         = '0;
        req_ch.r_small_density = '0;
        req_ch.r_large_density = '0;
        req_ch.k_small_density = '0;
        req_ch.k_large_density = '0;
        idle_pct               = 0;
        stall_pct              = 0;
        hold_rsp               = 1'b0;
        items                  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default grid unloaded, then a 2x2x2 grid
        send(1'b1, 4'd0, 4'd0, 4'd0);
        load_voxel();
        wait_idle();
        set_grid(2, 2, 2);
        set_window(0, 1'b0, MEASURE_RST);
        send(1'b1, 4'd1, 4'd1, 4'd1);
        for (int i = 0; i < 8; i++)
            load_voxel();
        load_voxel();
        send(1'b1, 4'd0, 4'd0, 4'd0);
        send(1'b1, 4'd1, 4'd1, 4'd1);
        send(1'b1, 4'd2, 4'd0, 4'd0);
        send(1'b1, 4'd0, 4'd0, 4'd2);
        send(1'b1, 4'd15, 4'd15, 4'd15);
        wait_idle();
        set_window(15, 1'b0, 32'hFFFF_FFFF);
        send(1'b1, 4'd0, 4'd1, 4'd0);
        wait_idle();
        set_window(15, 1'b1, 32'd0);
        send(1'b1, 4'd1, 4'd1, 4'd1);
        wait_idle();
        set_reg(CFG_MEASURE, 32'h0003_8000);
        send(1'b1, 4'd1, 4'd0, 4'd1);

        for (int ph = 0; items < ITEM_GOAL; ph++)
            random_phase(ph);

        wait_idle();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
